[rtl/core/iof_pkg.sv]
package iof_pkg;

  // Width of the working vectors (rates, gradient, raw quaternion).
  localparam int unsigned WORK_W = 52;

  localparam logic [31:0]        GAIN_RESET = 32'd6554;
  localparam logic [31:0]        STEP_RESET = 32'd2684355;
  localparam logic signed [31:0] Q_ONE      = 32'sh4000_0000;

  // Configuration register indexes.
  localparam logic [0:0] REG_GAIN = 1'b0;
  localparam logic [0:0] REG_STEP = 1'b1;

  typedef struct packed {
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } iof_sample_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } iof_quat_t;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    SRC_Q, SRC_GYRO, SRC_UNIT, SRC_SQ, SRC_GAIN, SRC_ONE
  } src_e;

  // Rounding right shift applied to a product.
  typedef enum logic [1:0] {
    RND_16, RND_17, RND_30
  } rnd_e;

  // Accumulator destinations.
  typedef enum logic [1:0] {
    DK_RATE, DK_VEC, DK_SQ
  } dkind_e;

  // Which vector the normalizer is working on.
  typedef enum logic [1:0] {
    PH_ACCEL, PH_GRAD, PH_FINAL
  } phase_e;

  // One multiply-accumulate step of the microprogram.
  typedef struct packed {
    src_e       a_src;
    logic [1:0] a_idx;
    src_e       b_src;
    logic [1:0] b_idx;
    rnd_e       rnd;
    logic [1:0] scl;
    logic       neg;
    logic       clr;
    dkind_e     dkind;
    logic [1:0] didx;
  } mac_op_t;

  localparam logic [5:0] PC_RATE_LAST  = 6'd11;
  localparam logic [5:0] PC_GRAD_FIRST = 6'd12;
  localparam logic [5:0] PC_GRAD_LAST  = 6'd39;
  localparam logic [5:0] PC_GAIN_FIRST = 6'd40;
  localparam logic [5:0] PC_GAIN_LAST  = 6'd43;

  function automatic mac_op_t mk(src_e a, logic [1:0] ai, src_e b, logic [1:0] bi,
                                 rnd_e r, logic [1:0] s, logic n, logic c,
                                 dkind_e d, logic [1:0] di);
    mac_op_t o;
    o.a_src = a;
    o.a_idx = ai;
    o.b_src = b;
    o.b_idx = bi;
    o.rnd   = r;
    o.scl   = s;
    o.neg   = n;
    o.clr   = c;
    o.dkind = d;
    o.didx  = di;
    return o;
  endfunction

  // Microprogram: rate quaternion, squares, gradient, gain correction.
  function automatic mac_op_t mac_op(logic [5:0] pc);
    mac_op_t o;
    unique case (pc)
      // Quaternion rate 0.5 * q (x) (0, g)
      6'd0:  o = mk(SRC_Q, 2'd1, SRC_GYRO, 2'd0, RND_17, 2'd0, 1'b1, 1'b1, DK_RATE, 2'd0);
      6'd1:  o = mk(SRC_Q, 2'd2, SRC_GYRO, 2'd1, RND_17, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd0);
      6'd2:  o = mk(SRC_Q, 2'd3, SRC_GYRO, 2'd2, RND_17, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd0);
      6'd3:  o = mk(SRC_Q, 2'd0, SRC_GYRO, 2'd0, RND_17, 2'd0, 1'b0, 1'b1, DK_RATE, 2'd1);
      6'd4:  o = mk(SRC_Q, 2'd3, SRC_GYRO, 2'd1, RND_17, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd1);
      6'd5:  o = mk(SRC_Q, 2'd2, SRC_GYRO, 2'd2, RND_17, 2'd0, 1'b0, 1'b0, DK_RATE, 2'd1);
      6'd6:  o = mk(SRC_Q, 2'd3, SRC_GYRO, 2'd0, RND_17, 2'd0, 1'b0, 1'b1, DK_RATE, 2'd2);
      6'd7:  o = mk(SRC_Q, 2'd0, SRC_GYRO, 2'd1, RND_17, 2'd0, 1'b0, 1'b0, DK_RATE, 2'd2);
      6'd8:  o = mk(SRC_Q, 2'd1, SRC_GYRO, 2'd2, RND_17, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd2);
      6'd9:  o = mk(SRC_Q, 2'd2, SRC_GYRO, 2'd0, RND_17, 2'd0, 1'b1, 1'b1, DK_RATE, 2'd3);
      6'd10: o = mk(SRC_Q, 2'd1, SRC_GYRO, 2'd1, RND_17, 2'd0, 1'b0, 1'b0, DK_RATE, 2'd3);
      6'd11: o = mk(SRC_Q, 2'd0, SRC_GYRO, 2'd2, RND_17, 2'd0, 1'b0, 1'b0, DK_RATE, 2'd3);
      // Squares of the quaternion elements
      6'd12: o = mk(SRC_Q, 2'd0, SRC_Q, 2'd0, RND_30, 2'd0, 1'b0, 1'b1, DK_SQ, 2'd0);
      6'd13: o = mk(SRC_Q, 2'd1, SRC_Q, 2'd1, RND_30, 2'd0, 1'b0, 1'b1, DK_SQ, 2'd1);
      6'd14: o = mk(SRC_Q, 2'd2, SRC_Q, 2'd2, RND_30, 2'd0, 1'b0, 1'b1, DK_SQ, 2'd2);
      6'd15: o = mk(SRC_Q, 2'd3, SRC_Q, 2'd3, RND_30, 2'd0, 1'b0, 1'b1, DK_SQ, 2'd3);
      // Gradient, first element
      6'd16: o = mk(SRC_Q, 2'd0, SRC_SQ, 2'd2, RND_30, 2'd2, 1'b0, 1'b1, DK_VEC, 2'd0);
      6'd17: o = mk(SRC_Q, 2'd2, SRC_UNIT, 2'd0, RND_30, 2'd1, 1'b0, 1'b0, DK_VEC, 2'd0);
      6'd18: o = mk(SRC_Q, 2'd0, SRC_SQ, 2'd1, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd0);
      6'd19: o = mk(SRC_Q, 2'd1, SRC_UNIT, 2'd1, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd0);
      // Gradient, second element
      6'd20: o = mk(SRC_Q, 2'd1, SRC_SQ, 2'd3, RND_30, 2'd2, 1'b0, 1'b1, DK_VEC, 2'd1);
      6'd21: o = mk(SRC_Q, 2'd3, SRC_UNIT, 2'd0, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd1);
      6'd22: o = mk(SRC_SQ, 2'd0, SRC_Q, 2'd1, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd1);
      6'd23: o = mk(SRC_Q, 2'd0, SRC_UNIT, 2'd1, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd1);
      6'd24: o = mk(SRC_Q, 2'd1, SRC_ONE, 2'd0, RND_30, 2'd2, 1'b1, 1'b0, DK_VEC, 2'd1);
      6'd25: o = mk(SRC_Q, 2'd1, SRC_SQ, 2'd1, RND_30, 2'd3, 1'b0, 1'b0, DK_VEC, 2'd1);
      6'd26: o = mk(SRC_Q, 2'd1, SRC_SQ, 2'd2, RND_30, 2'd3, 1'b0, 1'b0, DK_VEC, 2'd1);
      6'd27: o = mk(SRC_Q, 2'd1, SRC_UNIT, 2'd2, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd1);
      // Gradient, third element
      6'd28: o = mk(SRC_SQ, 2'd0, SRC_Q, 2'd2, RND_30, 2'd2, 1'b0, 1'b1, DK_VEC, 2'd2);
      6'd29: o = mk(SRC_Q, 2'd0, SRC_UNIT, 2'd0, RND_30, 2'd1, 1'b0, 1'b0, DK_VEC, 2'd2);
      6'd30: o = mk(SRC_Q, 2'd2, SRC_SQ, 2'd3, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd2);
      6'd31: o = mk(SRC_Q, 2'd3, SRC_UNIT, 2'd1, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd2);
      6'd32: o = mk(SRC_Q, 2'd2, SRC_ONE, 2'd0, RND_30, 2'd2, 1'b1, 1'b0, DK_VEC, 2'd2);
      6'd33: o = mk(SRC_Q, 2'd2, SRC_SQ, 2'd1, RND_30, 2'd3, 1'b0, 1'b0, DK_VEC, 2'd2);
      6'd34: o = mk(SRC_Q, 2'd2, SRC_SQ, 2'd2, RND_30, 2'd3, 1'b0, 1'b0, DK_VEC, 2'd2);
      6'd35: o = mk(SRC_Q, 2'd2, SRC_UNIT, 2'd2, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd2);
      // Gradient, fourth element
      6'd36: o = mk(SRC_SQ, 2'd1, SRC_Q, 2'd3, RND_30, 2'd2, 1'b0, 1'b1, DK_VEC, 2'd3);
      6'd37: o = mk(SRC_Q, 2'd1, SRC_UNIT, 2'd0, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd3);
      6'd38: o = mk(SRC_SQ, 2'd2, SRC_Q, 2'd3, RND_30, 2'd2, 1'b0, 1'b0, DK_VEC, 2'd3);
      6'd39: o = mk(SRC_Q, 2'd2, SRC_UNIT, 2'd1, RND_30, 2'd1, 1'b1, 1'b0, DK_VEC, 2'd3);
      // Gain correction subtracted from the rate
      6'd40: o = mk(SRC_GAIN, 2'd0, SRC_UNIT, 2'd0, RND_16, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd0);
      6'd41: o = mk(SRC_GAIN, 2'd0, SRC_UNIT, 2'd1, RND_16, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd1);
      6'd42: o = mk(SRC_GAIN, 2'd0, SRC_UNIT, 2'd2, RND_16, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd2);
      6'd43: o = mk(SRC_GAIN, 2'd0, SRC_UNIT, 2'd3, RND_16, 2'd0, 1'b1, 1'b0, DK_RATE, 2'd3);
      default: o = mk(SRC_Q, 2'd0, SRC_Q, 2'd0, RND_30, 2'd0, 1'b0, 1'b1, DK_SQ, 2'd0);
    endcase
    return o;
  endfunction

endpackage

[rtl/core/imu_orientation_filter.sv]
// The time from the accepted transaction to the result is longest when the correction runs,
// shorter when the gradient is zero and shortest when the accel vector is zero.
// Each normalization finds the maximum, pre-shifts, sums the squares, takes a square root and
// divides each element. The rest is 44 MAC steps and the integration of the four elements.
// One sample at a time: the next can be taken in the cycle after the result register is loaded.
// Reset (asynchronous, active low) loads the identity quaternion and default registers.
module imu_orientation_filter
  import iof_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  iof_sample_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output iof_quat_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_MUL      = 16'h0002,
    S_ACC      = 16'h0004,
    S_LDACC    = 16'h0008,
    S_NMAX     = 16'h0010,
    S_NSHIFT   = 16'h0020,
    S_NSQMUL   = 16'h0040,
    S_NSQADD   = 16'h0080,
    S_NROOT    = 16'h0100,
    S_NDIVINIT = 16'h0200,
    S_NDIV     = 16'h0400,
    S_NDIVEND  = 16'h0800,
    S_ILO      = 16'h1000,
    S_IHI      = 16'h2000,
    S_IADD     = 16'h4000,
    S_DONE     = 16'h8000
  } state_e;

  state_e state_q, state_d, exit_st;
  phase_e phase_q;
  logic [5:0] pc_q, exit_pc;
  logic [1:0] idx_q;
  logic [4:0] cnt_q;
  logic       ok_q;
  logic       out_valid_q;
  logic [31:0] gain_q, step_q;
  logic signed [31:0] q_q [4];

  iof_sample_t in_q;
  logic signed [WORK_W-1:0] rate_q [4];
  logic signed [WORK_W-1:0] vec_q [4];
  logic signed [31:0] sq_q [4];
  logic signed [31:0] unit_q [4];
  logic [WORK_W-1:0] mag_q [4];
  logic [3:0] neg_q;
  logic [WORK_W-1:0] mx_q;
  logic [63:0] sum_q, rx_q, root_q;
  logic [62:0] bit_q;
  logic [31:0] rem_q;
  logic [30:0] quo_q;
  logic [31:0] acc_q;
  logic signed [65:0] prod_q;

  mac_op_t op;
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic [65:0] pmag;
  logic [WORK_W-1:0] rmag, tmag;
  logic signed [WORK_W-1:0] term, dcur, dnew;
  logic [WORK_W-1:0] vmag [4];
  logic [WORK_W-1:0] m01, m23, vmax;
  logic big;
  logic [63:0] trial, sq_total;
  logic root_ge;
  logic [30:0] tcur;
  logic [32:0] r2, r2sub;
  logic div_ge;
  logic signed [31:0] quo_s;
  logic [WORK_W-1:0] rmag_i, isum;
  logic signed [WORK_W-1:0] nq;
  logic exit_ok, out_free;

  assign op = mac_op(pc_q);

  // Operand source for the shared multiplier.
  function automatic logic signed [32:0] pick(src_e s, logic [1:0] i);
    logic signed [32:0] v;
    v = '0;
    unique case (s)
      SRC_Q:    v = 33'(q_q[i]);
      SRC_GYRO: begin
        unique case (i)
          2'd0:    v = 33'(in_q.gyro_x);
          2'd1:    v = 33'(in_q.gyro_y);
          default: v = 33'(in_q.gyro_z);
        endcase
      end
      SRC_UNIT: v = 33'(unit_q[i]);
      SRC_SQ:   v = 33'(sq_q[i]);
      SRC_GAIN: v = $signed({1'b0, gain_q});
      SRC_ONE:  v = 33'(Q_ONE);
      default:  v = '0;
    endcase
    return v;
  endfunction

  // Magnitude of the rate element being integrated.
  assign rmag_i = rate_q[idx_q][WORK_W-1] ? -rate_q[idx_q] : rate_q[idx_q];

  // Shared multiplier operand selection.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_MUL: begin
        op_a = pick(op.a_src, op.a_idx);
        op_b = pick(op.b_src, op.b_idx);
      end
      S_NSQMUL: begin
        op_a = $signed({2'b00, mag_q[idx_q][30:0]});
        op_b = $signed({2'b00, mag_q[idx_q][30:0]});
      end
      S_ILO: begin
        op_a = $signed({1'b0, rmag_i[31:0]});
        op_b = $signed({1'b0, step_q});
      end
      S_IHI: begin
        op_a = $signed(33'(rmag_i[WORK_W-1:32]));
        op_b = $signed({1'b0, step_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // Rounded, scaled and signed product for the accumulate step.
  assign pmag = prod_q[65] ? -prod_q : prod_q;

  always_comb begin
    unique case (op.rnd)
      RND_16:  rmag = WORK_W'((pmag + 66'd32768) >> 16);
      RND_17:  rmag = WORK_W'((pmag + 66'd65536) >> 17);
      RND_30:  rmag = WORK_W'((pmag + 66'd536870912) >> 30);
      default: rmag = '0;
    endcase
  end

  assign tmag = rmag << op.scl;
  assign term = (prod_q[65] ^ op.neg) ? -$signed(tmag) : $signed(tmag);

  always_comb begin
    unique case (op.dkind)
      DK_RATE: dcur = rate_q[op.didx];
      DK_VEC:  dcur = vec_q[op.didx];
      DK_SQ:   dcur = WORK_W'(sq_q[op.didx]);
      default: dcur = '0;
    endcase
  end

  assign dnew = op.clr ? term : dcur + term;

  // Normalizer: magnitudes and their maximum.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vmag[i] = vec_q[i][WORK_W-1] ? -vec_q[i] : vec_q[i];
    end
  end

  assign m01  = (vmag[0] > vmag[1]) ? vmag[0] : vmag[1];
  assign m23  = (vmag[2] > vmag[3]) ? vmag[2] : vmag[3];
  assign vmax = (m01 > m23) ? m01 : m23;
  assign big  = |mx_q[WORK_W-1:31];

  // Square root step and the sum of squares.
  assign sq_total = sum_q + prod_q[63:0];
  assign trial    = root_q + {1'b0, bit_q};
  assign root_ge  = rx_q >= trial;

  // Restoring division step; the dividend is the element shifted left by 30.
  assign tcur   = mag_q[idx_q][30:0];
  assign r2     = {rem_q, (cnt_q == '0) ? tcur[0] : 1'b0};
  assign r2sub  = r2 - {1'b0, root_q[31:0]};
  assign div_ge = r2 >= {1'b0, root_q[31:0]};
  assign quo_s  = neg_q[idx_q] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  // Integration: q + rate * dt with dt in Q0.32, rounded half away from zero.
  assign isum = WORK_W'(acc_q) + WORK_W'(prod_q[63:0]);
  assign nq   = WORK_W'(q_q[idx_q])
              + (rate_q[idx_q][WORK_W-1] ? -$signed(isum) : $signed(isum));

  // Where a normalization returns to.
  assign exit_ok = (state_q == S_NDIVEND);

  always_comb begin
    unique case (phase_q)
      PH_ACCEL: begin
        exit_st = exit_ok ? S_MUL : S_ILO;
        exit_pc = PC_GRAD_FIRST;
      end
      PH_GRAD: begin
        exit_st = exit_ok ? S_MUL : S_ILO;
        exit_pc = PC_GAIN_FIRST;
      end
      default: begin
        exit_st = S_DONE;
        exit_pc = PC_GAIN_FIRST;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_MUL;
      S_MUL:      state_d = S_ACC;
      S_ACC: begin
        priority if (pc_q == PC_RATE_LAST) state_d = S_LDACC;
        else if (pc_q == PC_GRAD_LAST) state_d = S_NMAX;
        else if (pc_q == PC_GAIN_LAST) state_d = S_ILO;
        else state_d = S_MUL;
      end
      S_LDACC:    state_d = S_NMAX;
      S_NMAX:     state_d = S_NSHIFT;
      S_NSHIFT:   state_d = big ? S_NSHIFT : S_NSQMUL;
      S_NSQMUL:   state_d = S_NSQADD;
      S_NSQADD: begin
        priority if (idx_q != 2'd3) state_d = S_NSQMUL;
        else if (sq_total == '0) state_d = exit_st;
        else state_d = S_NROOT;
      end
      S_NROOT:    if (bit_q[0]) state_d = S_NDIVINIT;
      S_NDIVINIT: state_d = S_NDIV;
      S_NDIV:     if (cnt_q == 5'd30) state_d = S_NDIVEND;
      S_NDIVEND:  state_d = (idx_q == 2'd3) ? exit_st : S_NDIVINIT;
      S_ILO:      state_d = S_IHI;
      S_IHI:      state_d = S_IADD;
      S_IADD:     state_d = (idx_q == 2'd3) ? S_NMAX : S_ILO;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and orientation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_ACCEL;
      pc_q        <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= GAIN_RESET;
      step_q      <= STEP_RESET;
      q_q[0]      <= Q_ONE;
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN: gain_q <= cfg_data_i;
          REG_STEP: step_q <= cfg_data_i;
          default:  gain_q <= gain_q;
        endcase
      end
      // A new result is loaded as the previous one leaves.
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) pc_q <= '0;
        S_ACC: begin
          priority if (pc_q == PC_GRAD_LAST) phase_q <= PH_GRAD;
          else if (pc_q == PC_GAIN_LAST) idx_q <= '0;
          else if (pc_q != PC_RATE_LAST) pc_q <= pc_q + 6'd1;
        end
        S_LDACC: phase_q <= PH_ACCEL;
        S_NSHIFT: if (!big) idx_q <= '0;
        S_NSQADD: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            ok_q <= (sq_total != '0);
            pc_q <= exit_pc;
          end
        end
        S_NROOT: if (bit_q[0]) idx_q <= '0;
        S_NDIVINIT: cnt_q <= '0;
        S_NDIV: cnt_q <= cnt_q + 5'd1;
        S_NDIVEND: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) pc_q <= exit_pc;
        end
        S_IADD: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) phase_q <= PH_FINAL;
        end
        S_DONE: begin
          if (out_free) begin
            if (ok_q) begin
              for (int i = 0; i < 4; i++) q_q[i] <= unit_q[i];
            end else begin
              q_q[0] <= Q_ONE;
              q_q[1] <= '0;
              q_q[2] <= '0;
              q_q[3] <= '0;
            end
          end
        end
        default: pc_q <= pc_q;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_valid_i) in_q <= in_data_i;
      S_MUL, S_NSQMUL, S_ILO: prod_q <= prod;
      S_IHI: begin
        prod_q <= prod;
        acc_q  <= 32'((prod_q[63:0] + 64'h8000_0000) >> 32);
      end
      S_ACC: begin
        unique case (op.dkind)
          DK_RATE: rate_q[op.didx] <= dnew;
          DK_VEC:  vec_q[op.didx]  <= dnew;
          DK_SQ:   sq_q[op.didx]   <= dnew[31:0];
          default: sq_q[op.didx]   <= dnew[31:0];
        endcase
      end
      S_LDACC: begin
        vec_q[0] <= WORK_W'(in_q.accel_x);
        vec_q[1] <= WORK_W'(in_q.accel_y);
        vec_q[2] <= WORK_W'(in_q.accel_z);
        vec_q[3] <= '0;
      end
      S_NMAX: begin
        for (int i = 0; i < 4; i++) begin
          mag_q[i] <= vmag[i];
          neg_q[i] <= vec_q[i][WORK_W-1];
        end
        mx_q <= vmax;
      end
      S_NSHIFT: begin
        if (big) begin
          for (int i = 0; i < 4; i++) mag_q[i] <= mag_q[i] >> 1;
          mx_q <= mx_q >> 1;
        end else begin
          sum_q <= '0;
        end
      end
      S_NSQADD: begin
        sum_q  <= sq_total;
        rx_q   <= sq_total;
        root_q <= '0;
        bit_q  <= {1'b1, 62'd0};
      end
      S_NROOT: begin
        if (root_ge) begin
          rx_q   <= rx_q - trial;
          root_q <= (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_NDIVINIT: begin
        rem_q <= 32'(tcur[30:1]);
        quo_q <= '0;
      end
      S_NDIV: begin
        rem_q <= div_ge ? r2sub[31:0] : r2[31:0];
        quo_q <= {quo_q[29:0], div_ge};
      end
      S_NDIVEND: unit_q[idx_q] <= quo_s;
      S_IADD: vec_q[idx_q] <= nq;
      default: acc_q <= acc_q;
    endcase
  end

  // Handshake and result ports; the orientation register doubles as the output register.
  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_data_o.quat_w = q_q[0];
  assign out_data_o.quat_x = q_q[1];
  assign out_data_o.quat_y = q_q[2];
  assign out_data_o.quat_z = q_q[3];

endmodule
